// File: sv/header_overview_field_extract_assert.svh
// Assertion macros for the header field extractor.
`ifndef HEADER_OVERVIEW_FIELD_EXTRACT_ASSERT_SVH
`define HEADER_OVERVIEW_FIELD_EXTRACT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define HFX_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define HFX_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HFX_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg)
`define HFX_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg)

`endif

`endif

// File: sv/hfx_pkg.sv
`default_nettype none

package hfx_pkg;

    localparam int unsigned MAX_HEADER_BYTES = 65536;
    localparam int unsigned NUM_FIELDS       = 7;
    localparam int unsigned KW_MAX           = 11;
    localparam int unsigned POS_W            = $clog2(MAX_HEADER_BYTES + 1);
    localparam int unsigned COL_W            = $clog2(KW_MAX + 1);

    typedef enum logic [2:0] {
        F_SUBJECT    = 3'd0,
        F_FROM       = 3'd1,
        F_DATE       = 3'd2,
        F_MESSAGE_ID = 3'd3,
        F_REFERENCES = 3'd4,
        F_BYTES      = 3'd5,
        F_LINES      = 3'd6
    } field_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MATCH,
        PH_SKIP,
        PH_VALUE
    } phase_t;

    typedef logic [COL_W-1:0] col_t;

    localparam logic [7:0]  CH_CR   = 8'h0D;
    localparam logic [7:0]  CH_LF   = 8'h0A;
    localparam logic [7:0]  CH_SP   = 8'h20;
    localparam logic [7:0]  CH_TAB  = 8'h09;
    localparam logic [7:0]  CH_FF   = 8'h0C;
    localparam logic [15:0] VAL_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
    } hdr_item_t;

    typedef struct packed {
        field_t      field_id;
        logic        present;
        logic [15:0] value_offset;
        logic [15:0] value_length;
        logic        too_long;
        logic        last_field;
    } fld_item_t;

    // Parser state as it stands after the current byte
    typedef struct packed {
        logic [NUM_FIELDS-1:0]        found;
        logic [NUM_FIELDS-1:0][15:0]  offsets;
        logic [NUM_FIELDS-1:0][15:0]  lengths;
        logic                         overflow;
    } snap_t;

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= "A" && b <= "Z")
        begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic col_t kw_len(input field_t k);
        col_t n;
        unique case (k)
            F_SUBJECT:    n = col_t'(8);
            F_FROM:       n = col_t'(5);
            F_DATE:       n = col_t'(5);
            F_MESSAGE_ID: n = col_t'(11);
            F_REFERENCES: n = col_t'(11);
            F_BYTES:      n = col_t'(6);
            F_LINES:      n = col_t'(6);
            default:      n = '0;
        endcase
        return n;
    endfunction

    // Keyword character at column col, counted from the first character
    function automatic logic [7:0] kw_char(input field_t k, input col_t col);
        logic [8*KW_MAX-1:0] s;
        col_t                idx;
        unique case (k)
            F_SUBJECT:    s = (8*KW_MAX)'("subject:");
            F_FROM:       s = (8*KW_MAX)'("from:");
            F_DATE:       s = (8*KW_MAX)'("date:");
            F_MESSAGE_ID: s = (8*KW_MAX)'("message-id:");
            F_REFERENCES: s = (8*KW_MAX)'("references:");
            F_BYTES:      s = (8*KW_MAX)'("bytes:");
            F_LINES:      s = (8*KW_MAX)'("lines:");
            default:      s = '0;
        endcase
        idx = col_t'(kw_len(k) - col - col_t'(1));
        return s[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// File: sv/hfx_scan.sv
`default_nettype none

module hfx_scan
    import hfx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire hdr_item_t item,
    output snap_t          snap
);

    logic [POS_W-1:0]            pos_reg, pos_next;
    logic                        line_start_reg;
    phase_t                      phase_reg, phase_next;
    field_t                      cand_reg, cand_next;
    col_t                        col_reg, col_next;
    logic [NUM_FIELDS-1:0]       found_reg, found_next;
    logic [NUM_FIELDS-1:0][15:0] off_reg, off_next;
    logic [NUM_FIELDS-1:0][15:0] len_reg, len_next;
    logic                        ovf_reg, ovf_next;

    logic [7:0]  b;
    logic [7:0]  lc;
    logic        eol;
    logic        ws;
    logic        sat;
    logic [31:0] pos_wide;
    logic [15:0] pos16;
    logic        kw_hit;
    logic        kw_done;
    logic        start_hit;
    field_t      start_k;

    // Decode the byte and the position
    always_comb
    begin
        b         = item.header_byte;
        lc        = fold_case(b);
        eol       = (b == CH_CR) || (b == CH_LF);
        ws        = (b == CH_SP) || (b == CH_TAB) || (b == CH_FF);
        sat       = (pos_reg >= POS_W'(MAX_HEADER_BYTES));
        pos_wide  = 32'(pos_reg);
        pos16     = (pos_wide > 32'(VAL_MAX)) ? VAL_MAX : pos_wide[15:0];
        pos_next  = sat ? pos_reg : pos_reg + POS_W'(1);
        ovf_next  = ovf_reg | sat;
        kw_hit    = (col_reg < kw_len(cand_reg)) && (lc == kw_char(cand_reg, col_reg));
        kw_done   = ((col_reg + col_t'(1)) >= kw_len(cand_reg));
    end

    // Find the first open field whose keyword starts with this byte
    always_comb
    begin
        start_hit = 1'b0;
        start_k   = F_SUBJECT;
        for (int k = NUM_FIELDS - 1; k >= 0; k--)
        begin
            if (lc == kw_char(field_t'(3'(k)), '0) && !found_reg[k])
            begin
                start_hit = 1'b1;
                start_k   = field_t'(3'(k));
            end
        end
    end

    // Next phase, candidate and keyword column
    always_comb
    begin
        phase_next = phase_reg;
        cand_next  = cand_reg;
        col_next   = col_reg;
        unique case (phase_reg)
            PH_VALUE:
            begin
                if (eol)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_SKIP:
            begin
                if (ws)
                begin
                    phase_next = PH_SKIP;
                end
                else if (eol)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_VALUE;
                end
            end
            PH_MATCH:
            begin
                if (kw_hit)
                begin
                    col_next   = col_reg + col_t'(1);
                    phase_next = kw_done ? PH_SKIP : PH_MATCH;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
                if (line_start_reg && start_hit)
                begin
                    cand_next  = start_k;
                    col_next   = col_t'(1);
                    phase_next = PH_MATCH;
                end
            end
        endcase
    end

    // Record value start and count value bytes
    always_comb
    begin
        found_next = found_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        if (phase_reg == PH_SKIP && !ws && !eol)
        begin
            found_next[cand_reg] = 1'b1;
            off_next[cand_reg]   = pos16;
            len_next[cand_reg]   = 16'd1;
        end
        else if (phase_reg == PH_VALUE && !eol && len_reg[cand_reg] != VAL_MAX)
        begin
            len_next[cand_reg] = len_reg[cand_reg] + 16'd1;
        end
    end

    assign snap.found    = found_next;
    assign snap.offsets  = off_next;
    assign snap.lengths  = len_next;
    assign snap.overflow = ovf_next;

    // Advance control state; drop back to the line start after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            line_start_reg <= 1'b1;
            phase_reg      <= PH_IDLE;
            cand_reg       <= F_SUBJECT;
            col_reg        <= '0;
            found_reg      <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                pos_reg        <= '0;
                line_start_reg <= 1'b1;
                phase_reg      <= PH_IDLE;
                cand_reg       <= F_SUBJECT;
                col_reg        <= '0;
                found_reg      <= '0;
                ovf_reg        <= 1'b0;
            end
            else
            begin
                pos_reg        <= pos_next;
                line_start_reg <= (b == CH_LF);
                phase_reg      <= phase_next;
                cand_reg       <= cand_next;
                col_reg        <= col_next;
                found_reg      <= found_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

    // Hold offsets and lengths; entries are only read once found
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            off_reg <= off_next;
            len_reg <= len_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/header_overview_field_extract.sv
`default_nettype none
`include "header_overview_field_extract_assert.svh"

// Header field extractor: takes a message header one byte per cycle on the hdr
// channel and, on the byte marked last_byte, emits seven field items on the fld
// channel (subject, from, date, message-id, references, bytes, lines, in that
// order) giving each value's byte offset and length. Each byte passes an input
// register and is then parsed, so a new byte is taken every cycle unless a final
// byte is held. The seven items of a header sit in a result bank and leave at one
// per cycle unless fld_stall holds them, starting the cycle after the final byte
// is parsed; the next header streams in meanwhile, and its own final byte waits
// in the input register only while the prior header's items are not all taken.
module header_overview_field_extract
    import hfx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      hdr_valid,
    output logic           hdr_stall,
    input  wire hdr_item_t hdr,
    output logic           fld_valid,
    input  wire logic      fld_stall,
    output fld_item_t      fld
);

    logic                        in_valid_reg;
    hdr_item_t                   in_item_reg;
    logic                        bank_busy_reg;
    field_t                      bank_idx_reg;
    logic [NUM_FIELDS-1:0]       bank_found_reg;
    logic [NUM_FIELDS-1:0][15:0] bank_off_reg;
    logic [NUM_FIELDS-1:0][15:0] bank_len_reg;
    logic                        bank_ovf_reg;

    snap_t snap;
    logic  hdr_accept;
    logic  fld_accept;
    logic  bank_last;
    logic  bank_free;
    logic  advance;
    logic  load;

    // Handshake and flow control
    assign bank_last  = (bank_idx_reg == F_LINES);
    assign fld_accept = bank_busy_reg && !fld_stall;
    assign bank_free  = !bank_busy_reg || (fld_accept && bank_last);
    assign advance    = in_valid_reg && (!in_item_reg.last_byte || bank_free);
    assign load       = advance && in_item_reg.last_byte;
    assign hdr_stall  = in_valid_reg && !advance;
    assign hdr_accept = hdr_valid && !hdr_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (hdr_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_accept)
        begin
            in_item_reg <= hdr;
        end
    end

    hfx_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .snap  (snap)
    );

    // Result bank control: load on the final byte, step one field per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_busy_reg <= 1'b0;
            bank_idx_reg  <= F_SUBJECT;
        end
        else if (load)
        begin
            bank_busy_reg <= 1'b1;
            bank_idx_reg  <= F_SUBJECT;
        end
        else if (fld_accept)
        begin
            if (bank_last)
            begin
                bank_busy_reg <= 1'b0;
                bank_idx_reg  <= F_SUBJECT;
            end
            else
            begin
                bank_idx_reg <= field_t'(bank_idx_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bank_found_reg <= snap.found;
            bank_off_reg   <= snap.offsets;
            bank_len_reg   <= snap.lengths;
            bank_ovf_reg   <= snap.overflow;
        end
    end

    // Drive the current field item
    always_comb
    begin
        fld_valid        = bank_busy_reg;
        fld.field_id     = bank_idx_reg;
        fld.present      = bank_found_reg[bank_idx_reg];
        fld.value_offset = fld.present ? bank_off_reg[bank_idx_reg] : 16'd0;
        fld.value_length = fld.present ? bank_len_reg[bank_idx_reg] : 16'd0;
        fld.too_long     = bank_ovf_reg;
        fld.last_field   = bank_last;
    end

    `HFX_ASSERT_NEXT(a_field_order, clk, rst_n, fld_valid && !fld_stall && !fld.last_field, fld_valid && (fld.field_id == field_t'($past(fld.field_id) + 3'd1)), "field items out of order")
    `HFX_ASSERT_NEXT(a_run_restart, clk, rst_n, fld_valid && !fld_stall && fld.last_field, !fld_valid || (fld.field_id == F_SUBJECT), "new run does not start at subject")
    `HFX_ASSERT_SAME(a_stall_cause, clk, rst_n, hdr_stall, in_valid_reg && in_item_reg.last_byte && fld_valid, "input stalled without a pending final byte and busy bank")
    `HFX_ASSERT_SAME(a_absent_zero, clk, rst_n, fld_valid && !fld.present, (fld.value_offset == 16'd0) && (fld.value_length == 16'd0), "absent field carries a value")

endmodule

`default_nettype wire

// File: bench/field_extract_checker.sv
`default_nettype none

// Watches both channels of the header field extractor, predicts the seven
// field items of each header from the bytes taken in, and compares them with
// the items that leave.
module field_extract_checker
    import hfx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      hdr_valid,
    input  wire logic      hdr_stall,
    input  wire hdr_item_t hdr,
    input  wire logic      fld_valid,
    input  wire logic      fld_stall,
    input  wire fld_item_t fld,
    output int             fail_count,
    output int             pending,
    output int             bytes_seen,
    output int             headers_seen,
    output int             fields_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser state of the header in flight
    logic [POS_W-1:0] byte_pos;
    logic             at_sol;
    phase_t           phase;
    field_t           cand;
    logic [3:0]       kw_col;
    logic [6:0]       found;
    logic [15:0]      val_offset [NUM_FIELDS];
    logic [15:0]      val_length [NUM_FIELDS];
    logic             overflow;

    fld_item_t expected_fields [$];

    function automatic string keyword_of(input field_t f);
        case (f)
            F_SUBJECT:    return "subject:";
            F_FROM:       return "from:";
            F_DATE:       return "date:";
            F_MESSAGE_ID: return "message-id:";
            F_REFERENCES: return "references:";
            F_BYTES:      return "bytes:";
            F_LINES:      return "lines:";
            default:      return "";
        endcase
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
    endfunction

    task automatic clear_parser();
        byte_pos = '0;
        at_sol   = 1'b1;
        phase    = PH_IDLE;
        cand     = F_SUBJECT;
        kw_col   = '0;
        found    = '0;
        overflow = 1'b0;
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            val_offset[k] = '0;
            val_length[k] = '0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        fail_count++;
    endtask

    // Advance the parser by one header byte; queue seven items on the last one
    task automatic parse_header_byte(input logic [7:0] b, input logic last);
        logic [15:0] pos16;
        logic        sol;
        logic        eol;
        logic        hit;
        logic [7:0]  lc;
        logic [7:0]  want_ch;
        string       kw;
        fld_item_t   r;
        sol = at_sol;
        lc  = to_lower(b);
        eol = (b == CH_CR) || (b == CH_LF);

        // Saturate the position; a byte beyond the limit marks the header too long
        if (byte_pos >= MAX_HEADER_BYTES)
        begin
            byte_pos = POS_W'(MAX_HEADER_BYTES);
            overflow = 1'b1;
        end
        pos16 = (byte_pos > VAL_MAX) ? VAL_MAX : byte_pos[15:0];
        if (byte_pos < MAX_HEADER_BYTES)
        begin
            byte_pos = byte_pos + 1'b1;
        end
        at_sol = (b == CH_LF);

        case (phase)
            PH_VALUE:
            begin
                if (eol)
                begin
                    phase = PH_IDLE;
                end
                else if (val_length[cand] != VAL_MAX)
                begin
                    val_length[cand] = val_length[cand] + 1'b1;
                end
            end
            PH_SKIP:
            begin
                if (b == CH_SP || b == CH_TAB || b == CH_FF)
                begin
                    phase = PH_SKIP;
                end
                else if (eol)
                begin
                    // empty value: leave the field open
                    phase = PH_IDLE;
                end
                else
                begin
                    found[cand]      = 1'b1;
                    val_offset[cand] = pos16;
                    val_length[cand] = 16'd1;
                    phase            = PH_VALUE;
                end
            end
            PH_MATCH:
            begin
                kw      = keyword_of(cand);
                want_ch = kw[kw_col];
                if (lc == want_ch)
                begin
                    kw_col = kw_col + 1'b1;
                    if (kw_col == kw.len())
                    begin
                        phase = PH_SKIP;
                    end
                end
                else
                begin
                    phase = PH_IDLE;
                end
            end
            default:
            begin
                phase = PH_IDLE;
                hit   = 1'b0;
                if (sol)
                begin
                    for (int k = 0; k < NUM_FIELDS; k++)
                    begin
                        kw      = keyword_of(field_t'(k));
                        want_ch = kw[0];
                        if (!hit && !found[k] && lc == want_ch)
                        begin
                            hit    = 1'b1;
                            cand   = field_t'(k);
                            kw_col = 4'd1;
                            phase  = PH_MATCH;
                        end
                    end
                end
            end
        endcase

        if (last)
        begin
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                r.field_id     = field_t'(k);
                r.present      = found[k];
                r.value_offset = found[k] ? val_offset[k] : 16'd0;
                r.value_length = found[k] ? val_length[k] : 16'd0;
                r.too_long     = overflow;
                r.last_field   = (k == NUM_FIELDS - 1);
                expected_fields.push_back(r);
            end
            headers_seen++;
            clear_parser();
        end
    endtask

    // Compare one item leaving the block with the oldest prediction
    task automatic check_field_item(input fld_item_t got);
        fld_item_t want;
        string     diff;
        if (expected_fields.size() == 0)
        begin
            report_mismatch($sformatf("field item %0d arrived with nothing expected",
                                      got.field_id));
            return;
        end
        want = expected_fields.pop_front();
        fields_checked++;
        diff = "";
        if (got.field_id !== want.field_id)         diff = {diff, " field_id"};
        if (got.present !== want.present)           diff = {diff, " present"};
        if (got.value_offset !== want.value_offset) diff = {diff, " value_offset"};
        if (got.value_length !== want.value_length) diff = {diff, " value_length"};
        if (got.too_long !== want.too_long)         diff = {diff, " too_long"};
        if (got.last_field !== want.last_field)     diff = {diff, " last_field"};
        if (diff != "")
        begin
            report_mismatch($sformatf("field %0d:%s; got %0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d",
                want.field_id, diff, got.present, got.value_offset, got.value_length,
                got.too_long, got.last_field, want.present, want.value_offset,
                want.value_length, want.too_long, want.last_field));
        end
    endtask

    // Sample both channels at each edge: outgoing items first, then the new byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_fields.delete();
            fail_count     = 0;
            bytes_seen     = 0;
            headers_seen   = 0;
            fields_checked = 0;
            pending       <= 0;
        end
        else
        begin
            if (fld_valid && !fld_stall)
            begin
                check_field_item(fld);
            end
            if (hdr_valid && !hdr_stall)
            begin
                bytes_seen++;
                parse_header_byte(hdr.header_byte, hdr.last_byte);
            end
            pending <= expected_fields.size();
        end
    end

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hfx_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_WAIT       = 14;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_BYTES   = 12;
    localparam int RANDOM_HEADERS = 2;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      hdr_valid;
    logic      hdr_stall;
    hdr_item_t hdr;
    logic      fld_valid;
    logic      fld_stall;
    fld_item_t fld;

    int fail_count;
    int pending;
    int bytes_seen;
    int headers_seen;
    int fields_checked;

    bit         calm;
    bit         hold_fields;
    int         quiet_cycles;
    int         random_bytes;
    int         random_headers;
    logic [7:0] header_text [$];
    string      field_names [NUM_FIELDS] = '{"subject:", "from:", "date:", "message-id:",
                                             "references:", "bytes:", "lines:"};

    always #(CLK_PERIOD / 2) clk = ~clk;

    header_overview_field_extract dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr       (hdr),
        .fld_valid (fld_valid),
        .fld_stall (fld_stall),
        .fld       (fld)
    );

    field_extract_checker field_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .hdr_valid      (hdr_valid),
        .hdr_stall      (hdr_stall),
        .hdr            (hdr),
        .fld_valid      (fld_valid),
        .fld_stall      (fld_stall),
        .fld            (fld),
        .fail_count     (fail_count),
        .pending        (pending),
        .bytes_seen     (bytes_seen),
        .headers_seen   (headers_seen),
        .fields_checked (fields_checked)
    );

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (hdr_valid && !hdr_stall) || (fld_valid && !fld_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** header_overview_field_extract: FAILED **");
            $finish;
        end
    end

    // Field receiver: random stall after each item, plus one long hold-off on request
    initial
    begin : field_receiver
        int wait_left;
        wait_left = 0;
        fld_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_fields)
            begin
                fld_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_fields = 1'b0;
                wait_left   = 0;
                fld_stall <= 1'b0;
            end
            else if (fld_valid && !fld_stall)
            begin
                wait_left = calm ? 0 : $urandom_range(0, MAX_WAIT);
                fld_stall <= (wait_left != 0);
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                fld_stall <= (wait_left != 0);
            end
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            header_text.push_back(s[i]);
        end
    endtask

    task automatic add_line(input string s, input bit crlf);
        add_text(s);
        if (crlf)
        begin
            header_text.push_back(CH_CR);
        end
        header_text.push_back(CH_LF);
    endtask

    // Append the first n characters of a field name with random letter case
    task automatic add_keyword(input int k, input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = field_names[k][i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
            begin
                c = c ^ 8'h20;
            end
            header_text.push_back(c);
        end
    endtask

    task automatic add_blank();
        case ($urandom_range(0, 2))
            0:       header_text.push_back(CH_SP);
            1:       header_text.push_back(CH_TAB);
            default: header_text.push_back(CH_FF);
        endcase
    endtask

    task automatic add_value_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF);
        header_text.push_back(c);
    endtask

    // Mostly field lines with random content, some broken keywords, noise and blanks
    task automatic build_random_header();
        int n_lines;
        int kind;
        int k;
        int keep;
        n_lines = $urandom_range(1, 2);
        repeat (n_lines)
        begin
            kind = $urandom_range(0, 9);
            k    = $urandom_range(0, NUM_FIELDS - 1);
            if (kind <= 6)
            begin
                add_keyword(k, field_names[k].len());
                repeat ($urandom_range(0, 2)) add_blank();
                repeat ($urandom_range(0, 5)) add_value_byte();
            end
            else if (kind == 7)
            begin
                add_keyword(k, $urandom_range(1, field_names[k].len() - 1));
                repeat ($urandom_range(1, 4)) header_text.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 6)) header_text.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1)
            begin
                header_text.push_back(CH_CR);
            end
            header_text.push_back(CH_LF);
        end
        // cut the header short now and then
        if ($urandom_range(0, 3) == 0)
        begin
            keep = $urandom_range(1, header_text.size());
            while (header_text.size() > keep)
            begin
                void'(header_text.pop_back());
            end
        end
    endtask

    // Offer one byte after a random gap and hold it until taken
    task automatic put_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            hdr_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hdr_valid <= 1'b1;
        hdr       <= '{header_byte: b, last_byte: last};
        do
            @(posedge clk);
        while (hdr_stall);
    endtask

    task automatic send_header();
        for (int i = 0; i < header_text.size(); i++)
        begin
            put_byte(header_text[i], i == header_text.size() - 1);
        end
        header_text.delete();
    endtask

    // Drop valid and wait until every predicted item has left
    task automatic drain_fields();
        hdr_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        hdr_valid <= 1'b0;
        hdr       <= '0;
        calm           = 1'b0;
        hold_fields    = 1'b0;
        random_bytes   = 0;
        random_headers = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every field, mixed case, each blank kind, an empty value left open, a blank
        // line, NUL and 0xFF data; the last value ends at the last byte
        add_line("SUBJECT: a", 1'b1);
        add_line("date:", 1'b0);
        add_line("", 1'b0);
        add_text("from:");
        header_text.push_back(CH_TAB);
        add_text("b");
        header_text.push_back(8'h00);
        header_text.push_back(8'hFF);
        add_line("", 1'b0);
        add_text("Date:");
        header_text.push_back(CH_FF);
        add_line("c", 1'b1);
        add_line("Message-ID:d", 1'b0);
        add_line("References:e", 1'b0);
        add_line("BYTES:1", 1'b0);
        add_text("Lines: 3");
        send_header();
        drain_fields();

        // hold the receiver while short headers stream back to back: a value starting
        // on the last byte, a header ending while skipping, a keyword cut short
        calm        = 1'b1;
        hold_fields = 1'b1;
        add_text("From:y");
        send_header();
        add_text("lines:");
        header_text.push_back(CH_TAB);
        send_header();
        add_text("Lin");
        send_header();
        drain_fields();
        calm = 1'b0;

        // random headers under random gaps and stalls
        while (random_bytes < RANDOM_BYTES || random_headers < RANDOM_HEADERS)
        begin
            build_random_header();
            random_bytes += header_text.size();
            send_header();
            random_headers++;
        end

        drain_fields();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d header bytes in %0d headers: all field names, empty values, cut keywords.",
                 bytes_seen, headers_seen);
        $display("Compared %0d field items under random stalls, a long hold-off and a drain.",
                 fields_checked);
        if (fail_count == 0 && pending == 0)
        begin
            $display("** header_overview_field_extract: PASSED **");
        end
        else
        begin
            $display("** header_overview_field_extract: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
